@@ sv/fuzzy_obstacle_avoid_wheel_speed_core_macros.svh @@
`ifndef FUZZY_OBSTACLE_AVOID_WHEEL_SPEED_CORE_MACROS_SVH
`define FUZZY_OBSTACLE_AVOID_WHEEL_SPEED_CORE_MACROS_SVH

// checks that are off while reset is held
`define FZOA_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checks that also cover the reset cycles
`define FZOA_CHK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/fzoa_pkg.sv @@
package fzoa_pkg;

  localparam int DIST_W    = 12;
  localparam int MEM_W     = 9;
  localparam int NUM_SENS  = 4;
  localparam int NUM_RULES = 16;
  localparam int GRP       = 4;
  localparam int NUM_GRP   = NUM_RULES / GRP;
  localparam int GDEN_W    = 11;
  localparam int DEN_W     = 13;
  localparam int GNUM_W    = 14;
  localparam int NUM_W     = 16;
  localparam int MAG_W     = 15;
  localparam int Q_W       = 10;
  localparam int DVD_W     = MAG_W + Q_W;
  localparam int DVS_W     = 16;
  localparam int SPD_W     = 11;
  localparam int CONS_W    = 4;
  localparam int NUM_LANE  = 2;
  localparam int BITS_STG  = 2;
  localparam int DIV_STG   = Q_W / BITS_STG;

  localparam logic [MEM_W-1:0]  MEM_ONE = 9'd256;
  localparam logic [DIST_W-1:0] FAR_LO  = 12'd256;
  localparam logic [DIST_W-1:0] FAR_HI  = 12'd512;
  localparam logic [DVS_W-1:0]  DVS_MIN = 16'd1280;

  localparam logic signed [SPD_W-1:0] SPD_MAX = 11'sd512;
  localparam logic signed [SPD_W-1:0] SPD_MIN = -11'sd512;

  typedef logic [DIST_W-1:0]        dist_t;
  typedef logic [MEM_W-1:0]         memb_t;
  typedef logic signed [CONS_W-1:0] cons_t;
  typedef logic signed [SPD_W-1:0]  spd_t;

  // consequents in tenths of m/s, rule index k: bit 3 left .. bit 0 rear, set = near
  localparam cons_t CONS_L [NUM_RULES] = '{
    4'sd5, 4'sd5, -4'sd3, -4'sd3, 4'sd1, 4'sd1, -4'sd3, -4'sd3,
    4'sd3, 4'sd3, 4'sd3, 4'sd3, 4'sd3, 4'sd3, -4'sd3, -4'sd3
  };
  localparam cons_t CONS_R [NUM_RULES] = '{
    4'sd5, 4'sd5, 4'sd3, 4'sd3, 4'sd3, 4'sd3, 4'sd3, 4'sd3,
    4'sd1, 4'sd1, -4'sd3, -4'sd3, 4'sd3, 4'sd3, 4'sd3, 4'sd3
  };

  typedef struct packed {
    logic [NUM_LANE-1:0]            neg;
    logic [NUM_LANE-1:0][DVD_W-1:0] dvd;
    logic [DVS_W-1:0]               dvs;
  } div_in_t;

  function automatic memb_t far_of(dist_t d);
    dist_t diff;
    diff = d - FAR_LO;
    if (d <= FAR_LO) begin
      return '0;
    end else if (d >= FAR_HI) begin
      return MEM_ONE;
    end else begin
      return diff[MEM_W-1:0];
    end
  endfunction

endpackage

@@ sv/fuzzy_obstacle_avoid_wheel_speed_core.sv @@
// Fuzzy obstacle avoider: four sonar distances in, two wheel speeds out.
// Input channel: in_valid/in_ready with in_dist_left, in_dist_right,
// in_dist_front, in_dist_rear (12-bit unsigned, 1/256 m).
// Result channel: out_valid/out_ready with out_left_speed and
// out_right_speed (11-bit two's complement, 1/1024 m/s, toward zero).
// Every item gives exactly one result item.
// Pipeline from acceptance to out_valid: membership and rule strength
// registers, weighted-sum registers, restoring divider stages at
// 2 quotient bits per stage, and the sign register.
// Throughput: one item per cycle while not stalled; the divider stages set the depth.
// Stall: the whole pipeline holds while out_valid is high and out_ready
// is low; in_ready is low for those cycles and nothing is lost.
// Reset: synchronous, active-low rst_n empties the pipeline by clearing
// the valid bits; data registers are not reset and there is no clearing pass.
`include "fuzzy_obstacle_avoid_wheel_speed_core_macros.svh"

module fuzzy_obstacle_avoid_wheel_speed_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  fzoa_pkg::dist_t in_dist_left,
  input  fzoa_pkg::dist_t in_dist_right,
  input  fzoa_pkg::dist_t in_dist_front,
  input  fzoa_pkg::dist_t in_dist_rear,
  output logic            out_valid,
  input  logic            out_ready,
  output fzoa_pkg::spd_t  out_left_speed,
  output fzoa_pkg::spd_t  out_right_speed
);

  logic              en;
  logic              rule_v, acc_v;
  fzoa_pkg::dist_t   sonar  [fzoa_pkg::NUM_SENS];
  fzoa_pkg::memb_t   weight [fzoa_pkg::NUM_RULES];
  fzoa_pkg::div_in_t div_in;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign sonar[0] = in_dist_left;
  assign sonar[1] = in_dist_right;
  assign sonar[2] = in_dist_front;
  assign sonar[3] = in_dist_rear;

  fzoa_rules u_rules (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .sonar     (sonar),
    .out_valid (rule_v),
    .weight    (weight)
  );

  fzoa_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rule_v),
    .weight    (weight),
    .out_valid (acc_v),
    .div_in    (div_in)
  );

  fzoa_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (acc_v),
    .div_in      (div_in),
    .out_valid   (out_valid),
    .left_speed  (out_left_speed),
    .right_speed (out_right_speed)
  );

  `FZOA_CHK(a_left_range, out_valid |-> out_left_speed <= fzoa_pkg::SPD_MAX && out_left_speed >= fzoa_pkg::SPD_MIN, "left speed out of range")
  `FZOA_CHK(a_right_range, out_valid |-> out_right_speed <= fzoa_pkg::SPD_MAX && out_right_speed >= fzoa_pkg::SPD_MIN, "right speed out of range")
  `FZOA_CHK_RST(a_rst_flush, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

@@ sv/fzoa_rules.sv @@
module fzoa_rules (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  fzoa_pkg::dist_t        sonar [fzoa_pkg::NUM_SENS],
  output logic                   out_valid,
  output fzoa_pkg::memb_t        weight [fzoa_pkg::NUM_RULES]
);

  logic            v1_r, v2_r;
  fzoa_pkg::memb_t far_r  [fzoa_pkg::NUM_SENS];
  fzoa_pkg::memb_t near_r [fzoa_pkg::NUM_SENS];
  fzoa_pkg::memb_t far_nxt  [fzoa_pkg::NUM_SENS];
  fzoa_pkg::memb_t near_nxt [fzoa_pkg::NUM_SENS];
  fzoa_pkg::memb_t w_r   [fzoa_pkg::NUM_RULES];
  fzoa_pkg::memb_t w_nxt [fzoa_pkg::NUM_RULES];

  always_comb begin
    for (int s = 0; s < fzoa_pkg::NUM_SENS; s++) begin
      far_nxt[s]  = fzoa_pkg::far_of(sonar[s]);
      near_nxt[s] = fzoa_pkg::MEM_ONE - far_nxt[s];
    end
  end

  always_comb begin
    fzoa_pkg::memb_t w;
    fzoa_pkg::memb_t cand;
    for (int k = 0; k < fzoa_pkg::NUM_RULES; k++) begin
      w = fzoa_pkg::MEM_ONE;
      for (int s = 0; s < fzoa_pkg::NUM_SENS; s++) begin
        cand = (((k >> (fzoa_pkg::NUM_SENS - 1 - s)) & 1) != 0) ? near_r[s] : far_r[s];
        if (cand < w) begin
          w = cand;
        end
      end
      w_nxt[k] = w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      far_r  <= far_nxt;
      near_r <= near_nxt;
      w_r    <= w_nxt;
    end
  end

  assign out_valid = v2_r;
  assign weight    = w_r;

endmodule

@@ sv/fzoa_accum.sv @@
module fzoa_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  fzoa_pkg::memb_t   weight [fzoa_pkg::NUM_RULES],
  output logic              out_valid,
  output fzoa_pkg::div_in_t div_in
);

  logic                              va_r, vb_r;
  logic [fzoa_pkg::GDEN_W-1:0]        gden_r   [fzoa_pkg::NUM_GRP];
  logic [fzoa_pkg::GDEN_W-1:0]        gden_nxt [fzoa_pkg::NUM_GRP];
  logic signed [fzoa_pkg::GNUM_W-1:0] gnum_r   [fzoa_pkg::NUM_GRP][fzoa_pkg::NUM_LANE];
  logic signed [fzoa_pkg::GNUM_W-1:0] gnum_nxt [fzoa_pkg::NUM_GRP][fzoa_pkg::NUM_LANE];
  fzoa_pkg::div_in_t                 div_r, div_nxt;

  // group sums of four rules each
  always_comb begin
    logic signed [fzoa_pkg::GNUM_W-1:0] wv;
    int k;
    for (int g = 0; g < fzoa_pkg::NUM_GRP; g++) begin
      gden_nxt[g]    = '0;
      gnum_nxt[g][0] = '0;
      gnum_nxt[g][1] = '0;
      for (int j = 0; j < fzoa_pkg::GRP; j++) begin
        k  = g * fzoa_pkg::GRP + j;
        wv = fzoa_pkg::GNUM_W'(signed'({1'b0, weight[k]}));
        gden_nxt[g]    = gden_nxt[g] + fzoa_pkg::GDEN_W'(weight[k]);
        gnum_nxt[g][0] = gnum_nxt[g][0] + wv * fzoa_pkg::GNUM_W'(fzoa_pkg::CONS_L[k]);
        gnum_nxt[g][1] = gnum_nxt[g][1] + wv * fzoa_pkg::GNUM_W'(fzoa_pkg::CONS_R[k]);
      end
    end
  end

  // totals, sign and magnitude, divisor = 10 * den, dividend = |num| * 1024
  always_comb begin
    logic [fzoa_pkg::DEN_W-1:0]        den;
    logic [fzoa_pkg::DVS_W-1:0]        den_x;
    logic signed [fzoa_pkg::NUM_W-1:0] num;
    logic signed [fzoa_pkg::NUM_W-1:0] mag;
    den = '0;
    for (int g = 0; g < fzoa_pkg::NUM_GRP; g++) begin
      den = den + fzoa_pkg::DEN_W'(gden_r[g]);
    end
    den_x       = fzoa_pkg::DVS_W'(den);
    div_nxt.dvs = (den_x << 3) + (den_x << 1);
    for (int l = 0; l < fzoa_pkg::NUM_LANE; l++) begin
      num = '0;
      for (int g = 0; g < fzoa_pkg::NUM_GRP; g++) begin
        num = num + fzoa_pkg::NUM_W'(gnum_r[g][l]);
      end
      div_nxt.neg[l] = num[fzoa_pkg::NUM_W-1];
      mag            = num[fzoa_pkg::NUM_W-1] ? -num : num;
      div_nxt.dvd[l] = {mag[fzoa_pkg::MAG_W-1:0], {fzoa_pkg::Q_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gden_r <= gden_nxt;
      gnum_r <= gnum_nxt;
      div_r  <= div_nxt;
    end
  end

  assign out_valid = vb_r;
  assign div_in    = div_r;

endmodule

@@ sv/fzoa_div.sv @@
`include "fuzzy_obstacle_avoid_wheel_speed_core_macros.svh"

module fzoa_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  fzoa_pkg::div_in_t div_in,
  output logic              out_valid,
  output fzoa_pkg::spd_t    left_speed,
  output fzoa_pkg::spd_t    right_speed
);

  localparam int NS = fzoa_pkg::DIV_STG;
  localparam int NL = fzoa_pkg::NUM_LANE;

  logic                       vs_r   [NS];
  logic [fzoa_pkg::DVS_W-1:0] dvs_r  [NS];
  logic [fzoa_pkg::DVD_W-1:0] rem_r  [NS][NL];
  logic [fzoa_pkg::Q_W-1:0]   q_r    [NS][NL];
  logic                       neg_r  [NS][NL];
  logic [fzoa_pkg::DVD_W-1:0] rem_nxt [NS][NL];
  logic [fzoa_pkg::Q_W-1:0]   q_nxt   [NS][NL];

  logic                       vo_r;
  fzoa_pkg::spd_t             spd_r   [NL];
  fzoa_pkg::spd_t             spd_nxt [NL];

  for (genvar s = 0; s < NS; s++) begin : g_stg
    logic                       src_v;
    logic [fzoa_pkg::DVS_W-1:0] src_dvs;
    logic [fzoa_pkg::DVD_W-1:0] src_rem [NL];
    logic [fzoa_pkg::Q_W-1:0]   src_q   [NL];
    logic                       src_neg [NL];

    if (s == 0) begin : g_head
      always_comb begin
        src_v   = in_valid;
        src_dvs = div_in.dvs;
        for (int l = 0; l < NL; l++) begin
          src_rem[l] = div_in.dvd[l];
          src_q[l]   = '0;
          src_neg[l] = div_in.neg[l];
        end
      end
    end else begin : g_body
      always_comb begin
        src_v   = vs_r[s-1];
        src_dvs = dvs_r[s-1];
        for (int l = 0; l < NL; l++) begin
          src_rem[l] = rem_r[s-1][l];
          src_q[l]   = q_r[s-1][l];
          src_neg[l] = neg_r[s-1][l];
        end
      end
    end

    // restoring division, two quotient bits per stage, msb first
    always_comb begin
      logic [fzoa_pkg::DVD_W:0]   sh;
      logic [fzoa_pkg::DVD_W-1:0] rem;
      logic [fzoa_pkg::Q_W-1:0]   q;
      int                         i;
      for (int l = 0; l < NL; l++) begin
        rem = src_rem[l];
        q   = src_q[l];
        for (int b = 0; b < fzoa_pkg::BITS_STG; b++) begin
          i  = fzoa_pkg::Q_W - 1 - (s * fzoa_pkg::BITS_STG + b);
          sh = (fzoa_pkg::DVD_W + 1)'(src_dvs) << i;
          if ({1'b0, rem} >= sh) begin
            rem  = rem - sh[fzoa_pkg::DVD_W-1:0];
            q[i] = 1'b1;
          end
        end
        rem_nxt[s][l] = rem;
        q_nxt[s][l]   = q;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[s] <= 1'b0;
      end else if (en) begin
        vs_r[s] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dvs_r[s] <= src_dvs;
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
        neg_r[s] <= src_neg;
      end
    end
  end

  // sign back on, truncation toward zero
  always_comb begin
    fzoa_pkg::spd_t mag;
    for (int l = 0; l < NL; l++) begin
      mag        = fzoa_pkg::SPD_W'(q_r[NS-1][l]);
      spd_nxt[l] = neg_r[NS-1][l] ? -mag : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= vs_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spd_r <= spd_nxt;
    end
  end

  assign out_valid   = vo_r;
  assign left_speed  = spd_r[0];
  assign right_speed = spd_r[1];

  `FZOA_CHK(a_dvs_floor, in_valid |-> div_in.dvs >= fzoa_pkg::DVS_MIN, "divisor below floor")
  `FZOA_CHK(a_rem_left, vs_r[NS-1] |-> rem_r[NS-1][0] < fzoa_pkg::DVD_W'(dvs_r[NS-1]), "left remainder not reduced")
  `FZOA_CHK(a_rem_right, vs_r[NS-1] |-> rem_r[NS-1][1] < fzoa_pkg::DVD_W'(dvs_r[NS-1]), "right remainder not reduced")

endmodule
